// File: rtl/gea_pkg.sv
// shared constants and types for the geared encoder angle tracker
`default_nettype none
package gea_pkg;
    localparam int C_CNT_W     = 13;
    localparam int C_RANGE     = 2 ** C_CNT_W;
    localparam int C_HALF      = C_RANGE / 2;
    localparam int C_WINDOW    = 4000;
    localparam int C_RATIO_W   = 6;
    localparam int C_MAX_RATIO = 36;
    localparam int C_POS_W     = 19;
    localparam int C_ANG_W     = 16;
    localparam int C_ANG_MAX   = 18000;
    localparam int C_MAG_W     = C_POS_W - 1;
    localparam int C_ANG_SHIFT = 8;
    localparam int C_ANG_MUL   = 36000 * (2 ** C_ANG_SHIFT) / C_RANGE;
    localparam int C_MUL_W     = 11;
    localparam int C_PROD_W    = C_MAG_W + C_MUL_W;
    localparam int C_NUM_W     = C_PROD_W - C_ANG_SHIFT;
    localparam int C_STEP_W    = 5;
    localparam int C_CFG_IDX_W = 1;
    localparam int C_CFG_W     = 13;

    localparam logic [C_CFG_IDX_W-1:0] C_REG_ZERO_OFFSET = 1'b0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_GEAR_RATIO  = 1'b1;

    typedef struct packed {
        logic signed [C_POS_W-1:0] pos;
        logic [C_RATIO_W-1:0]      ratio;
        logic [C_RATIO_W-1:0]      idx;
    } t_entry;
endpackage
`default_nettype wire

// File: rtl/geared_encoder_angle_tracker.sv
// top level of the geared encoder angle tracker
//  channel  | direction | handshake     | words
//  input    | in        | push / full   | i_raw_count
//  result   | out       | empty / pop   | o_shaft_position, o_angle_centideg, o_turn_index
//  config   | in        | i_cfg_we      | i_cfg_idx, i_cfg_data
// a word passes the combinational front and waits in a two-entry queue
// the back takes one word at a time: a take state, a multiply state, a restoring
// divide by the gear ratio, one quotient bit per cycle, then load
// synchronous active-low reset clears turn state, queue and result valid flag
// full rises when the queue holds two words; a held result stalls the back, which stops popping the queue
`default_nettype none
module geared_encoder_angle_tracker (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  push,
    output logic                                 full,
    input  wire [gea_pkg::C_CNT_W-1:0]           i_raw_count,
    output logic                                 empty,
    input  wire                                  pop,
    output logic signed [gea_pkg::C_POS_W-1:0]   o_shaft_position,
    output logic signed [gea_pkg::C_ANG_W-1:0]   o_angle_centideg,
    output logic [gea_pkg::C_RATIO_W-1:0]        o_turn_index,
    input  wire                                  i_cfg_we,
    input  wire [gea_pkg::C_CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [gea_pkg::C_CFG_W-1:0]           i_cfg_data
);
    import gea_pkg::*;

    logic [C_CNT_W-1:0]   r_zero_offset;
    logic [C_RATIO_W-1:0] r_gear_ratio;
    logic                 take;
    t_entry               f_entry;
    t_entry               q_entry;
    logic                 q_empty;
    logic                 q_pop;

    assign take = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= '0;
            r_gear_ratio  <= C_RATIO_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                C_REG_ZERO_OFFSET: r_zero_offset <= i_cfg_data[C_CNT_W-1:0];
                C_REG_GEAR_RATIO:  r_gear_ratio  <= i_cfg_data[C_RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    gea_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_raw_count   (i_raw_count),
        .i_zero_offset (r_zero_offset),
        .i_gear_ratio  (r_gear_ratio),
        .o_entry       (f_entry)
    );

    gea_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_entry (q_entry),
        .o_empty (q_empty)
    );

    gea_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_entry          (q_entry),
        .o_q_pop          (q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_shaft_position (o_shaft_position),
        .o_angle_centideg (o_angle_centideg),
        .o_turn_index     (o_turn_index)
    );

`ifndef SYNTHESIS
    a_turn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_turn_index < C_RATIO_W'(C_MAX_RATIO))
        else $error("turn index out of range");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_angle_centideg <= C_ANG_W'(C_ANG_MAX))
                && (o_angle_centideg >= -C_ANG_W'(C_ANG_MAX)))
        else $error("angle out of range");

    a_angle_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_angle_centideg < 0) |-> o_shaft_position < 0)
        else $error("angle sign disagrees with position");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_shaft_position))
        else $error("waiting result changed");
`endif
endmodule
`default_nettype wire

// File: rtl/gea_front.sv
// front stage: offset correction, turn tracking and shaft position
`default_nettype none
module gea_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_take,
    input  wire [gea_pkg::C_CNT_W-1:0]   i_raw_count,
    input  wire [gea_pkg::C_CNT_W-1:0]   i_zero_offset,
    input  wire [gea_pkg::C_RATIO_W-1:0] i_gear_ratio,
    output gea_pkg::t_entry              o_entry
);
    import gea_pkg::*;

    logic [C_CNT_W-1:0]   r_prev, n_prev;
    logic [C_RATIO_W-1:0] r_tc, n_tc;

    logic [C_RATIO_W-1:0]      eff_r;
    logic signed [C_CNT_W+1:0] st_pos;
    logic [C_CNT_W:0]          off_hi;
    logic [C_CNT_W-1:0]        cur;
    logic [C_RATIO_W-1:0]      tc0;
    logic [C_RATIO_W-1:0]      tc1;
    logic [C_POS_W-1:0]        total;
    logic [C_POS_W-1:0]        lim;
    logic [C_POS_W:0]          span;
    logic [C_POS_W:0]          mt_pos;
    logic                      up, down;

    always_comb begin
        if (i_gear_ratio == '0) begin
            eff_r = C_RATIO_W'(1);
        end else if (i_gear_ratio > C_RATIO_W'(C_MAX_RATIO)) begin
            eff_r = C_RATIO_W'(C_MAX_RATIO);
        end else begin
            eff_r = i_gear_ratio;
        end

        // single-turn folding
        off_hi = {1'b0, i_zero_offset} + (C_CNT_W+1)'(C_HALF);
        st_pos = $signed({2'b00, i_raw_count}) - $signed({2'b00, i_zero_offset});
        if (i_zero_offset < C_CNT_W'(C_HALF)) begin
            if ({1'b0, i_raw_count} > off_hi) begin
                st_pos = st_pos - (C_CNT_W+2)'(C_RANGE);
            end
        end else begin
            if (i_raw_count < i_zero_offset - C_CNT_W'(C_HALF)) begin
                st_pos = st_pos + (C_CNT_W+2)'(C_RANGE);
            end
        end

        // multi-turn tracking
        cur  = i_raw_count - i_zero_offset;
        tc0  = (r_tc >= eff_r) ? '0 : r_tc;
        up   = (r_prev > C_CNT_W'(C_RANGE - C_WINDOW)) && (cur < C_CNT_W'(C_WINDOW));
        down = (r_prev < C_CNT_W'(C_WINDOW)) && (cur > C_CNT_W'(C_RANGE - C_WINDOW));
        tc1  = tc0;
        if (up) begin
            tc1 = (tc0 + 1'b1 == eff_r) ? '0 : tc0 + 1'b1;
        end else if (down) begin
            tc1 = (tc0 == '0) ? eff_r - 1'b1 : tc0 - 1'b1;
        end
        total  = {tc1, cur};
        lim    = {1'b0, eff_r, {(C_CNT_W-1){1'b0}}};
        span   = {1'b0, eff_r, {C_CNT_W{1'b0}}};
        mt_pos = (total > lim) ? {1'b0, total} - span : {1'b0, total};

        o_entry.ratio = eff_r;
        if (eff_r == C_RATIO_W'(1)) begin
            o_entry.pos = C_POS_W'(st_pos);
            o_entry.idx = '0;
            n_prev      = r_prev;
            n_tc        = r_tc;
        end else begin
            o_entry.pos = mt_pos[C_POS_W-1:0];
            o_entry.idx = tc1;
            n_prev      = cur;
            n_tc        = tc1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_tc   <= '0;
        end else if (i_take) begin
            r_prev <= n_prev;
            r_tc   <= n_tc;
        end
    end
endmodule
`default_nettype wire

// File: rtl/gea_queue.sv
// two-entry queue between front and back stages
`default_nettype none
module gea_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  gea_pkg::t_entry i_entry,
    output logic            o_full,
    input  wire             i_pop,
    output gea_pkg::t_entry o_entry,
    output logic            o_empty
);
    import gea_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end
endmodule
`default_nettype wire

// File: rtl/gea_back.sv
// back stage: angle scaling, serial divide by ratio, result register
`default_nettype none
module gea_back (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_q_empty,
    input  gea_pkg::t_entry                 i_entry,
    output logic                            o_q_pop,
    input  wire                             i_pop,
    output logic                            o_empty,
    output logic signed [gea_pkg::C_POS_W-1:0] o_shaft_position,
    output logic signed [gea_pkg::C_ANG_W-1:0] o_angle_centideg,
    output logic [gea_pkg::C_RATIO_W-1:0]   o_turn_index
);
    import gea_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0]          r_state;
    logic [C_STEP_W-1:0] r_step;
    t_entry              r_cur;
    logic [C_NUM_W-1:0]  r_quo;
    logic [C_RATIO_W:0]  r_rem;
    logic                r_out_valid;

    logic [C_MAG_W-1:0]  mag;
    logic [C_POS_W-1:0]  neg_pos;
    logic [C_PROD_W-1:0] prod;
    logic [C_RATIO_W:0]  trial;
    logic                fits;
    logic [C_ANG_W-1:0]  q_ang;
    logic                out_free;

    assign o_empty  = !r_out_valid;
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        neg_pos = -r_cur.pos;
        mag     = r_cur.pos[C_POS_W-1] ? neg_pos[C_MAG_W-1:0] : r_cur.pos[C_MAG_W-1:0];
        prod    = C_PROD_W'(mag) * C_PROD_W'(C_ANG_MUL);
        trial   = {r_rem[C_RATIO_W-1:0], r_quo[C_NUM_W-1]};
        fits    = trial >= {1'b0, r_cur.ratio};
        q_ang   = r_quo[C_ANG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_WAIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == C_STEP_W'(C_NUM_W - 1)) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && !i_q_empty) begin
            r_cur <= i_entry;
        end
        if (r_state == S_MUL) begin
            r_quo <= prod[C_PROD_W-1:C_ANG_SHIFT];
            r_rem <= '0;
        end else if (r_state == S_DIV) begin
            r_quo <= {r_quo[C_NUM_W-2:0], fits};
            r_rem <= fits ? trial - {1'b0, r_cur.ratio} : trial;
        end
        if (r_state == S_WAIT && out_free) begin
            o_shaft_position <= r_cur.pos;
            o_angle_centideg <= r_cur.pos[C_POS_W-1] ? -q_ang : q_ang;
            o_turn_index     <= r_cur.idx;
        end
    end
endmodule
`default_nettype wire

// File: tb/tb_geared_encoder_angle_tracker.sv
// self-checking testbench for the geared encoder angle tracker
`default_nettype none
module tb_geared_encoder_angle_tracker;
    timeunit 1ns;
    timeprecision 1ps;
    import gea_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 30;

    typedef struct {
        logic signed [C_POS_W-1:0] pos;
        logic signed [C_ANG_W-1:0] angle;
        logic [C_RATIO_W-1:0]      idx;
    } shaft_word_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        full;
    logic [C_CNT_W-1:0]          i_raw_count = '0;
    logic                        empty;
    logic                        pop = 1'b0;
    logic signed [C_POS_W-1:0]   o_shaft_position;
    logic signed [C_ANG_W-1:0]   o_angle_centideg;
    logic [C_RATIO_W-1:0]        o_turn_index;
    logic                        i_cfg_we = 1'b0;
    logic [C_CFG_IDX_W-1:0]      i_cfg_idx = '0;
    logic [C_CFG_W-1:0]          i_cfg_data = '0;

    // mirror of block state and registers
    logic [C_CNT_W-1:0]   zero_offset_q = '0;
    logic [C_RATIO_W-1:0] gear_ratio_q = 6'd1;
    logic [C_CNT_W-1:0]   prev_count_q = '0;
    logic [C_RATIO_W-1:0] turn_q = '0;

    shaft_word_t shaft_words_due[$];
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned n_errors = 0;
    int unsigned n_words_in = 0;
    int unsigned n_words_out = 0;
    int unsigned n_settings = 0;
    int unsigned idle_cycles = 0;

    geared_encoder_angle_tracker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_raw_count      (i_raw_count),
        .empty            (empty),
        .pop              (pop),
        .o_shaft_position (o_shaft_position),
        .o_angle_centideg (o_angle_centideg),
        .o_turn_index     (o_turn_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic shaft_word_t track_shaft(input logic [C_CNT_W-1:0] raw);
        longint rng;
        longint half;
        longint off;
        longint t;
        longint cur;
        longint last;
        longint total;
        longint p;
        longint a;
        logic [C_RATIO_W-1:0] ratio;
        shaft_word_t w;
        rng = longint'(C_RANGE);
        half = rng / 2;
        off = longint'(zero_offset_q);
        ratio = gear_ratio_q;
        if (ratio == 0) ratio = C_RATIO_W'(1);
        if (ratio > C_MAX_RATIO) ratio = C_RATIO_W'(C_MAX_RATIO);
        if (ratio == 1) begin
            t = longint'(raw);
            if (off < half) begin
                if (t > off + half) t -= rng;
            end else if (t < off - half) begin
                t += rng;
            end
            p = t - off;
            a = (p * 36000) / rng;
            w.idx = '0;
        end else begin
            cur = longint'(raw) - off;
            if (cur < 0) cur += rng;
            last = longint'(prev_count_q);
            if (turn_q >= ratio) turn_q = '0;
            if (last > rng - C_WINDOW && cur < C_WINDOW) begin
                turn_q = turn_q + 1'b1;
                if (turn_q >= ratio) turn_q = '0;
            end else if (last < C_WINDOW && cur > rng - C_WINDOW) begin
                if (turn_q == 0) turn_q = ratio - 1'b1;
                else turn_q = turn_q - 1'b1;
            end
            prev_count_q = cur[C_CNT_W-1:0];
            total = cur + longint'(turn_q) * rng;
            if (total > longint'(ratio) * half) p = total - longint'(ratio) * rng;
            else p = total;
            a = (p * 36000) / (rng * longint'(ratio));
            w.idx = turn_q;
        end
        w.pos = p[C_POS_W-1:0];
        w.angle = a[C_ANG_W-1:0];
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_word();
        shaft_word_t w;
        n_words_out++;
        if (shaft_words_due.size() == 0) begin
            report_mismatch("result word with nothing expected");
        end else begin
            w = shaft_words_due.pop_front();
            if (o_shaft_position !== w.pos)
                report_mismatch($sformatf("shaft_position got %0d expected %0d",
                                          o_shaft_position, w.pos));
            if (o_angle_centideg !== w.angle)
                report_mismatch($sformatf("angle_centideg got %0d expected %0d",
                                          o_angle_centideg, w.angle));
            if (o_turn_index !== w.idx)
                report_mismatch($sformatf("turn_index got %0d expected %0d",
                                          o_turn_index, w.idx));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) check_word();
        pop <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[geared_encoder_angle_tracker] ERROR");
            $finish;
        end
    end

    task automatic send_count(input logic [C_CNT_W-1:0] raw);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_raw_count <= raw;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        shaft_words_due.push_back(track_shaft(raw));
        n_words_in++;
    endtask

    task automatic drain_words();
        push <= 1'b0;
        while (shaft_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx,
                             input logic [C_CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == C_REG_ZERO_OFFSET) zero_offset_q = data;
        else gear_ratio_q = data[C_RATIO_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [C_CNT_W-1:0] offset,
                              input logic [C_RATIO_W-1:0] ratio);
        logic [C_CFG_W-1:0] data;
        data = C_CFG_W'($urandom);
        data[C_RATIO_W-1:0] = ratio;
        drain_words();
        write_reg(C_REG_ZERO_OFFSET, offset);
        write_reg(C_REG_GEAR_RATIO, data);
        n_settings++;
    endtask

    task automatic test_single_turn();
        send_count(13'd0);
        send_count(13'd4097);
        send_count(13'd8191);
        set_config(13'd8191, 6'd1);
        send_count(13'd0);
        send_count(13'd4095);
        send_count(13'd8191);
        set_config(13'd4096, 6'd1);
        send_count(13'd0);
        send_count(13'd8191);
        set_config(13'd4095, 6'd1);
        send_count(13'd8191);
        send_count(13'd0);
    endtask

    task automatic test_multi_turn();
        set_config(13'd0, 6'd2);
        send_count(13'd1000);
        send_count(13'd7000);
        send_count(13'd100);
        send_count(13'd6000);
        send_count(13'd200);
        send_count(13'd8100);
    endtask

    task automatic test_ratio_limits();
        set_config(13'd100, 6'd0);
        send_count(13'd8000);
        // above the maximum ratio, then back to two with a stale counter
        set_config(13'd0, 6'd63);
        send_count(13'd8000);
        send_count(13'd100);
        send_count(13'd4150);
        send_count(13'd8000);
        send_count(13'd100);
        set_config(13'd0, 6'd2);
        send_count(13'd5000);
    endtask

    task automatic test_random_tracking();
        int unsigned phase_idle[4];
        int unsigned phase_stall[4];
        int motion;
        int vel;
        logic [C_CNT_W-1:0] raw;
        logic [C_CNT_W-1:0] offset;
        logic [C_RATIO_W-1:0] ratio;
        phase_idle = '{0, 78, 0, 6};
        phase_stall = '{0, 0, 78, 6};
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = phase_idle[ph];
            stall_pct = phase_stall[ph];
            for (int s = 0; s < 5; s++) begin
                case ($urandom_range(9))
                    0: ratio = 6'd1;
                    1: ratio = 6'd2;
                    2: ratio = C_RATIO_W'(C_MAX_RATIO);
                    3: ratio = 6'd0;
                    4: ratio = C_RATIO_W'($urandom_range(63, C_MAX_RATIO + 1));
                    default: ratio = C_RATIO_W'($urandom_range(C_MAX_RATIO - 1, 3));
                endcase
                case ($urandom_range(3))
                    0: offset = '0;
                    1: offset = '1;
                    default: offset = C_CNT_W'($urandom);
                endcase
                set_config(offset, ratio);
                motion = int'($urandom_range(C_RANGE - 1));
                vel = int'($urandom_range(3000)) - 1500;
                for (int k = 0; k < 27; k++) begin
                    if ($urandom_range(99) < 15) begin
                        case ($urandom_range(7))
                            0: raw = '0;
                            1: raw = '1;
                            2: raw = C_CNT_W'(C_WINDOW - 1);
                            3: raw = C_CNT_W'(C_WINDOW);
                            4: raw = C_CNT_W'(C_RANGE - C_WINDOW);
                            5: raw = C_CNT_W'(C_RANGE - C_WINDOW + 1);
                            6: raw = C_CNT_W'(C_HALF);
                            default: raw = C_CNT_W'($urandom);
                        endcase
                    end else begin
                        if ($urandom_range(9) == 0) vel = int'($urandom_range(3000)) - 1500;
                        motion = motion + vel + int'($urandom_range(64)) - 32;
                        raw = motion[C_CNT_W-1:0];
                    end
                    send_count(raw);
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_turn();
        test_multi_turn();
        test_ratio_limits();
        test_random_tracking();
        drain_words();
        if (shaft_words_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", shaft_words_due.size()));
        $display("%0d readings in, %0d results checked over %0d register settings",
                 n_words_in, n_words_out, n_settings);
        $display("single-turn and geared modes, ratio clamping, idle and stall mixes");
        if (n_errors == 0) begin
            $display("[geared_encoder_angle_tracker] OK");
        end else begin
            $display("[geared_encoder_angle_tracker] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
